FILE: rtl/core/aevd_pkg.sv
// shared constants for the attitude error / vortex ring detector
// holds datapath widths, cordic angle table and angle limits; no dependencies

package aevd_pkg;

  // width of the euler argument words ahead of the cordic units
  localparam int unsigned G_W = 34;
  // cordic x/y word width, leaves room for the gain and the pre-rotation
  localparam int unsigned CW = G_W + 3;
  // angle accumulator width, unit is 0.01 deg * 2^16
  localparam int unsigned ACC_W = 33;
  // number of right shift candidates in the normalizer
  localparam int unsigned RSH_N = 19;
  // restoring square root steps, one result bit each
  localparam int unsigned ISQ_STEPS = 31;
  localparam int unsigned ISQ_W = 2 * ISQ_STEPS;

  localparam logic signed [ACC_W-1:0] ACC_90 = 33'sd589824000;
  localparam logic signed [ACC_W-1:0] ACC_HALF = 33'sd32768;
  localparam logic signed [15:0] ANG_MAX = 16'sd18000;
  localparam logic signed [15:0] PITCH_MAX = 16'sd9000;
  localparam logic signed [15:0] VRS_ANG = 16'sd500;
  localparam logic [14:0] HOVER_RST = 15'd5000;

  // atan(2^-i) in 0.01 deg * 2^16
  localparam logic signed [ACC_W-1:0] AtanTab [24] = '{
    33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
    33'sd23437865, 33'sd11730358, 33'sd5866610, 33'sd2933484,
    33'sd1466765, 33'sd733385, 33'sd366693, 33'sd183346,
    33'sd91673, 33'sd45837, 33'sd22918, 33'sd11459,
    33'sd5730, 33'sd2865, 33'sd1432, 33'sd716,
    33'sd358, 33'sd179, 33'sd90, 33'sd45
  };

endpackage

FILE: rtl/core/aevd_cordic.sv
// pipelined vectoring cordic, atan2(y, x) in 0.01 deg with rounding and clamp
// one micro-rotation per stage; uses aevd_pkg for widths and the angle table

module aevd_cordic #(
  parameter int unsigned ITERS = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [aevd_pkg::G_W-1:0] y_i,
  input  logic signed [aevd_pkg::G_W-1:0] x_i,
  output logic signed [15:0]              ang_o
);
  import aevd_pkg::*;

  logic signed [CW-1:0]    xs_q  [ITERS+1];
  logic signed [CW-1:0]    ys_q  [ITERS+1];
  logic signed [ACC_W-1:0] acc_q [ITERS+1];
  logic                    zero_q[ITERS+1];

  logic signed [CW-1:0]    x_e, y_e, x_p, y_p;
  logic signed [ACC_W-1:0] acc_p, rnd;
  logic signed [15:0]      ang_d, ang_q;

  // quadrant pre-rotation for the left half plane
  always_comb begin
    x_e   = CW'(x_i);
    y_e   = CW'(y_i);
    x_p   = x_e;
    y_p   = y_e;
    acc_p = '0;
    if (x_e < 0) begin
      if (y_e >= 0) begin
        x_p   = y_e;
        y_p   = -x_e;
        acc_p = ACC_90;
      end else begin
        x_p   = -y_e;
        y_p   = x_e;
        acc_p = -ACC_90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]   <= x_p;
      ys_q[0]   <= y_p;
      acc_q[0]  <= acc_p;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ys_q[i] >= 0) begin
          xs_q[i+1]  <= xs_q[i] + (ys_q[i] >>> i);
          ys_q[i+1]  <= ys_q[i] - (xs_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] + AtanTab[i];
        end else begin
          xs_q[i+1]  <= xs_q[i] - (ys_q[i] >>> i);
          ys_q[i+1]  <= ys_q[i] + (xs_q[i] >>> i);
          acc_q[i+1] <= acc_q[i] - AtanTab[i];
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  always_comb begin
    rnd = (acc_q[ITERS] + ACC_HALF) >>> 16;
    if (zero_q[ITERS]) begin
      ang_d = '0;
    end else if (rnd > ACC_W'(ANG_MAX)) begin
      ang_d = ANG_MAX;
    end else if (rnd < -ACC_W'(ANG_MAX)) begin
      ang_d = -ANG_MAX;
    end else begin
      ang_d = rnd[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign ang_o = ang_q;

endmodule

FILE: rtl/core/attitude_error_vrs_detect.sv
// pipeline depth is set by the 31-step square root and the cordic stages of the pitch
// path; throughput: one word per cycle while the output is not stalled
// a stall at the output freezes the whole pipeline in place
// reset clears all valid bits and loads hover velocity 5000
// top level of the attitude error / vortex ring detector
// depends on aevd_pkg and aevd_cordic

module attitude_error_vrs_detect #(
  parameter int unsigned ANGLE_ITERS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tgt_w, tgt_x, tgt_y, tgt_z, cur_w, cur_x, cur_y, cur_z, vel_x, vel_y, vel_z
  input  logic [175:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // roll_err, pitch_err, yaw_err, vrs_detected
  output logic [47:0]  m_axis_tdata_o
);
  import aevd_pkg::*;

  typedef struct packed {
    logic sat;
    logic sneg;
    logic vz_ok;
    logic h_ok;
  } flags_t;

  localparam int unsigned CLat = ANGLE_ITERS + 2;
  localparam int unsigned RyDly = ISQ_STEPS + 2;
  localparam int unsigned FlDly = ISQ_STEPS + 2 + CLat;
  localparam int unsigned Lat = 7 + ISQ_STEPS + 3 + CLat;

  logic           adv;
  logic [Lat-1:0] vld_q;
  logic [14:0]    hover_q;

  assign adv             = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hover_q <= HOVER_RST;
    end else if (cfg_we_i) begin
      hover_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
    end
  end

  // stage a: capture, identity substitution, vertical test, velocity squares
  logic signed [15:0] t_in[4], c_in[4];
  logic signed [15:0] vx, vy, vz;
  logic signed [23:0] vz100, vh28;
  logic               t_zero, c_zero;

  logic signed [15:0] a_t_q[4], a_c_q[4];
  logic signed [31:0] a_vx2_q, a_vy2_q;
  logic [29:0]        a_vh2_q;
  logic               a_vz_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t_in[i] = s_axis_tdata_i[16*i +: 16];
      c_in[i] = s_axis_tdata_i[16*(4+i) +: 16];
    end
    t_zero = (s_axis_tdata_i[63:0] == '0);
    c_zero = (s_axis_tdata_i[127:64] == '0);
    if (t_zero) t_in[0] = 16'sd16384;
    if (c_zero) c_in[0] = 16'sd16384;
    vx    = s_axis_tdata_i[143:128];
    vy    = s_axis_tdata_i[159:144];
    vz    = s_axis_tdata_i[175:160];
    vz100 = 24'(vz) * 24'sd100;
    vh28  = 24'(signed'({1'b0, hover_q})) * 24'sd28;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_t_q   <= t_in;
      a_c_q   <= c_in;
      a_vx2_q <= 32'(vx) * 32'(vx);
      a_vy2_q <= 32'(vy) * 32'(vy);
      a_vh2_q <= 30'(hover_q) * 30'(hover_q);
      a_vz_q  <= vz100 < -vh28;
    end
  end

  // stage b: sixteen partial products, horizontal test on squares
  logic signed [31:0] b_p_q[4][4];
  logic               b_vz_q, b_h_q;
  logic [39:0]        hsum, h100, vh49;

  always_comb begin
    hsum = 40'($unsigned(a_vx2_q)) + 40'($unsigned(a_vy2_q));
    h100 = hsum * 40'd100;
    vh49 = 40'(a_vh2_q) * 40'd49;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          b_p_q[i][j] <= 32'(a_t_q[i]) * 32'(a_c_q[j]);
        end
      end
      b_vz_q <= a_vz_q;
      b_h_q  <= h100 < vh49;
    end
  end

  // stage c: error quaternion target * conj(measured)
  logic signed [G_W-1:0] c_e_q[4];
  logic                  c_vz_q, c_h_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_e_q[0] <= G_W'(b_p_q[0][0]) + G_W'(b_p_q[1][1]) + G_W'(b_p_q[2][2])
                + G_W'(b_p_q[3][3]);
      c_e_q[1] <= -G_W'(b_p_q[0][1]) + G_W'(b_p_q[1][0]) - G_W'(b_p_q[2][3])
                + G_W'(b_p_q[3][2]);
      c_e_q[2] <= -G_W'(b_p_q[0][2]) + G_W'(b_p_q[1][3]) + G_W'(b_p_q[2][0])
                - G_W'(b_p_q[3][1]);
      c_e_q[3] <= -G_W'(b_p_q[0][3]) - G_W'(b_p_q[1][2]) + G_W'(b_p_q[2][1])
                + G_W'(b_p_q[3][0]);
      c_vz_q   <= b_vz_q;
      c_h_q    <= b_h_q;
    end
  end

  // stage d: pick the normalizing shift, right until below 2^15, left up to 2^14
  logic [RSH_N-1:0]      fit;
  logic signed [G_W-1:0] tmp;
  logic [15:0]           mg;
  logic [14:0]           magor;
  logic [4:0]            rk_d;
  logic [3:0]            lj_d;

  logic signed [G_W-1:0] d_e_q[4];
  logic [4:0]            d_rk_q;
  logic [3:0]            d_lj_q;
  logic                  d_vz_q, d_h_q;

  always_comb begin
    fit = '1;
    for (int k = 0; k < RSH_N; k++) begin
      for (int i = 0; i < 4; i++) begin
        tmp = c_e_q[i] >>> k;
        if (tmp < -34'sd32767 || tmp > 34'sd32767) fit[k] = 1'b0;
      end
    end
    rk_d = 5'(RSH_N - 1);
    for (int k = RSH_N - 1; k >= 0; k--) begin
      if (fit[k]) rk_d = 5'(k);
    end
    magor = '0;
    for (int i = 0; i < 4; i++) begin
      mg    = c_e_q[i][15] ? 16'(-c_e_q[i][15:0]) : c_e_q[i][15:0];
      magor = magor | mg[14:0];
    end
    lj_d = '0;
    for (int b = 0; b < 15; b++) begin
      if (magor[b]) lj_d = 4'(14 - b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_e_q  <= c_e_q;
      d_rk_q <= rk_d;
      d_lj_q <= lj_d;
      d_vz_q <= c_vz_q;
      d_h_q  <= c_h_q;
    end
  end

  // stage e: apply the shift
  logic signed [15:0]    q_n[4];
  logic signed [G_W-1:0] shr;
  logic signed [15:0]    e_q[4];
  logic                  e_vz_q, e_h_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      shr = d_e_q[i] >>> d_rk_q;
      if (d_rk_q != '0) begin
        q_n[i] = shr[15:0];
      end else begin
        q_n[i] = 16'(d_e_q[i][15:0] << d_lj_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q    <= q_n;
      e_vz_q <= d_vz_q;
      e_h_q  <= d_h_q;
    end
  end

  // stage f: quadratic terms
  logic signed [31:0] f_ww_q, f_xx_q, f_yy_q, f_zz_q, f_wx_q;
  logic signed [31:0] f_yz_q, f_wz_q, f_xy_q, f_wy_q, f_zx_q;
  logic               f_vz_q, f_h_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_ww_q <= 32'(e_q[0]) * 32'(e_q[0]);
      f_xx_q <= 32'(e_q[1]) * 32'(e_q[1]);
      f_yy_q <= 32'(e_q[2]) * 32'(e_q[2]);
      f_zz_q <= 32'(e_q[3]) * 32'(e_q[3]);
      f_wx_q <= 32'(e_q[0]) * 32'(e_q[1]);
      f_yz_q <= 32'(e_q[2]) * 32'(e_q[3]);
      f_wz_q <= 32'(e_q[0]) * 32'(e_q[3]);
      f_xy_q <= 32'(e_q[1]) * 32'(e_q[2]);
      f_wy_q <= 32'(e_q[0]) * 32'(e_q[2]);
      f_zx_q <= 32'(e_q[3]) * 32'(e_q[1]);
      f_vz_q <= e_vz_q;
      f_h_q  <= e_h_q;
    end
  end

  // stage g: atan2 arguments and the pitch sine / norm
  logic signed [G_W-1:0] g_ry_q, g_rx_q, g_yy_q, g_yx_q, g_s_q, g_n_q;
  logic                  g_vz_q, g_h_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_ry_q <= (G_W'(f_wx_q) + G_W'(f_yz_q)) <<< 1;
      g_rx_q <= G_W'(f_ww_q) + G_W'(f_zz_q) - G_W'(f_xx_q) - G_W'(f_yy_q);
      g_yy_q <= (G_W'(f_wz_q) + G_W'(f_xy_q)) <<< 1;
      g_yx_q <= G_W'(f_ww_q) + G_W'(f_xx_q) - G_W'(f_yy_q) - G_W'(f_zz_q);
      g_s_q  <= (G_W'(f_wy_q) - G_W'(f_zx_q)) <<< 1;
      g_n_q  <= G_W'(f_ww_q) + G_W'(f_xx_q) + G_W'(f_yy_q) + G_W'(f_zz_q);
      g_vz_q <= f_vz_q;
      g_h_q  <= f_h_q;
    end
  end

  logic signed [15:0] roll_c, yaw_c, pitch_c;

  aevd_cordic #(.ITERS(ANGLE_ITERS)) u_roll (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (g_ry_q),
    .x_i   (g_rx_q),
    .ang_o (roll_c)
  );

  aevd_cordic #(.ITERS(ANGLE_ITERS)) u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (g_yy_q),
    .x_i   (g_yx_q),
    .ang_o (yaw_c)
  );

  // stage h: saturation check and quarter-scaled root operands
  logic [G_W-1:0] sabs, dsum, psum;
  logic [30:0]    h_as2_q, h_d2_q, h_p2_q;
  flags_t         fl_d;
  flags_t         fl_q[FlDly];

  always_comb begin
    sabs       = g_s_q[G_W-1] ? G_W'(-g_s_q) : G_W'(g_s_q);
    dsum       = G_W'(g_n_q) - sabs;
    psum       = G_W'(g_n_q) + sabs;
    fl_d.sat   = sabs >= G_W'(g_n_q);
    fl_d.sneg  = g_s_q[G_W-1];
    fl_d.vz_ok = g_vz_q;
    fl_d.h_ok  = g_h_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_as2_q <= sabs[32:2];
      h_d2_q  <= dsum[32:2];
      h_p2_q  <= psum[32:2];
      fl_q[0] <= fl_d;
      for (int k = 1; k < FlDly; k++) begin
        fl_q[k] <= fl_q[k-1];
      end
    end
  end

  // stage i and square root steps, rem/res form, one result bit a stage
  logic [ISQ_W-1:0] sq_rem_q[ISQ_STEPS+1];
  logic [ISQ_W-1:0] sq_res_q[ISQ_STEPS+1];
  logic [30:0]      sq_as2_q[ISQ_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0] <= ISQ_W'(h_d2_q) * ISQ_W'(h_p2_q);
      sq_res_q[0] <= '0;
      sq_as2_q[0] <= h_as2_q;
    end
  end

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
    localparam logic [ISQ_W-1:0] Bit = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
    logic [ISQ_W-1:0] trial;
    assign trial = sq_res_q[k] + Bit;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sq_rem_q[k] >= trial) begin
          sq_rem_q[k+1] <= sq_rem_q[k] - trial;
          sq_res_q[k+1] <= (sq_res_q[k] >> 1) + Bit;
        end else begin
          sq_rem_q[k+1] <= sq_rem_q[k];
          sq_res_q[k+1] <= sq_res_q[k] >> 1;
        end
        sq_as2_q[k+1] <= sq_as2_q[k];
      end
    end
  end

  logic signed [G_W-1:0] p_y, p_x;
  assign p_y = G_W'(sq_as2_q[ISQ_STEPS]);
  assign p_x = G_W'(sq_res_q[ISQ_STEPS][30:0]);

  aevd_cordic #(.ITERS(ANGLE_ITERS)) u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (p_y),
    .x_i   (p_x),
    .ang_o (pitch_c)
  );

  // roll and yaw wait for the pitch path
  logic [31:0] ry_q[RyDly];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ry_q[0] <= {yaw_c, roll_c};
      for (int k = 1; k < RyDly; k++) begin
        ry_q[k] <= ry_q[k-1];
      end
    end
  end

  // output stage
  flags_t             fl_o;
  logic signed [15:0] roll_o, yaw_o, pmag, pitch_o;
  logic               vrs_d;
  logic [47:0]        out_q;

  always_comb begin
    fl_o   = fl_q[FlDly-1];
    roll_o = ry_q[RyDly-1][15:0];
    yaw_o  = ry_q[RyDly-1][31:16];
    if (fl_o.sat || pitch_c > PITCH_MAX) begin
      pmag = PITCH_MAX;
    end else begin
      pmag = pitch_c;
    end
    pitch_o = fl_o.sneg ? -pmag : pmag;
    vrs_d   = fl_o.vz_ok && fl_o.h_ok &&
              (roll_o > VRS_ANG || pitch_o > VRS_ANG || yaw_o > VRS_ANG);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {vrs_d, yaw_o, pitch_o[14:0], roll_o};
    end
  end

  assign m_axis_tdata_o = out_q;

endmodule

FILE: sim/attitude_error_vrs_detect_chk.sv
// checker for the attitude error / vortex ring detector: predicts each result word
// from accepted input words and compares it field by field; depends on nothing else

module attitude_error_vrs_detect_chk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [14:0]  cfg_wdata_i,
  input  logic         in_fire_i,
  input  logic [175:0] in_data_i,
  input  logic         out_fire_i,
  input  logic [47:0]  out_data_i,
  output int           err_cnt_o,
  output int           pending_o
);

  localparam int NITER = 16;

  typedef struct packed {
    logic       vrs;
    logic [15:0] yaw;
    logic [14:0] pitch;
    logic [15:0] roll;
  } angles_t;

  localparam longint AtanLut [24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466765, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45
  };

  logic [14:0] hover_q;
  angles_t     angles_q[$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_floor(longint v);
    longint res, bt;
    res = 0;
    bt = 64'sd1 <<< 62;
    while (bt > v) bt = bt >>> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >>> 1) + bt;
      end else begin
        res = res >>> 1;
      end
      bt = bt >>> 2;
    end
    return res;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint acc, t, dx, dy, r;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 9000 * 65536;
      end else begin
        x = -y; y = t; acc = -9000 * 65536;
      end
    end
    for (int i = 0; i < NITER; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; acc += AtanLut[i];
      end else begin
        x -= dx; y += dy; acc -= AtanLut[i];
      end
    end
    r = fshr(acc + 32768, 16);
    if (r > 18000) r = 18000;
    if (r < -18000) r = -18000;
    return r;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic angles_t error_angles(logic [175:0] d, logic [14:0] hv);
    longint tq[4], cq[4], e[4], m, w, x, y, z, roll, pitch, yaw, s, n, vx, vy, vz, vh;
    angles_t a;
    for (int i = 0; i < 4; i++) begin
      tq[i] = longint'($signed(d[16*i +: 16]));
      cq[i] = longint'($signed(d[16*(i+4) +: 16]));
    end
    if (tq[0] == 0 && tq[1] == 0 && tq[2] == 0 && tq[3] == 0) tq[0] = 16384;
    if (cq[0] == 0 && cq[1] == 0 && cq[2] == 0 && cq[3] == 0) cq[0] = 16384;
    e[0] = tq[0]*cq[0] + tq[1]*cq[1] + tq[2]*cq[2] + tq[3]*cq[3];
    e[1] = -tq[0]*cq[1] + tq[1]*cq[0] - tq[2]*cq[3] + tq[3]*cq[2];
    e[2] = -tq[0]*cq[2] + tq[1]*cq[3] + tq[2]*cq[0] - tq[3]*cq[1];
    e[3] = -tq[0]*cq[3] - tq[1]*cq[2] + tq[2]*cq[1] + tq[3]*cq[0];
    m = 0;
    for (int i = 0; i < 4; i++) if (absl(e[i]) > m) m = absl(e[i]);
    while (m >= 32768) begin
      m = 0;
      for (int i = 0; i < 4; i++) begin
        e[i] = fshr(e[i], 1);
        if (absl(e[i]) > m) m = absl(e[i]);
      end
    end
    while (m != 0 && m < 16384) begin
      for (int i = 0; i < 4; i++) e[i] = e[i] * 2;
      m = m * 2;
    end
    w = e[0]; x = e[1]; y = e[2]; z = e[3];
    roll = vec_angle(2*(w*x + y*z), w*w + z*z - x*x - y*y);
    yaw  = vec_angle(2*(w*z + x*y), w*w + x*x - y*y - z*z);
    s = 2*(w*y - z*x);
    n = w*w + x*x + y*y + z*z;
    if (absl(s) >= n) begin
      pitch = s < 0 ? -9000 : 9000;
    end else begin
      pitch = vec_angle(absl(s) >>> 2,
                        sqrt_floor(((n - absl(s)) >>> 2) * ((n + absl(s)) >>> 2)));
      if (pitch > 9000) pitch = 9000;
      if (s < 0) pitch = -pitch;
    end
    vx = longint'($signed(d[128 +: 16]));
    vy = longint'($signed(d[144 +: 16]));
    vz = longint'($signed(d[160 +: 16]));
    vh = longint'(hv);
    a.roll = roll[15:0];
    a.pitch = pitch[14:0];
    a.yaw = yaw[15:0];
    a.vrs = (vz*100 < -28*vh) && (100*(vx*vx + vy*vy) < 49*vh*vh)
            && (roll > 500 || pitch > 500 || yaw > 500);
    return a;
  endfunction

  assign pending_o = angles_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    angles_t exp_a, got;
    if (!rst_ni) begin
      hover_q <= 15'd5000;
      err_cnt_o <= 0;
      angles_q.delete();
    end else begin
      // write takes effect for words accepted after this edge; writes happen only when idle
      if (cfg_we_i) hover_q <= cfg_wdata_i;
      if (in_fire_i) angles_q.push_back(error_angles(in_data_i, hover_q));
      if (out_fire_i) begin
        got = out_data_i;
        if (angles_q.size() == 0) begin
          $error("unexpected result word %h", out_data_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_a = angles_q.pop_front();
          if (exp_a.roll != got.roll)
            $error("roll_err expected %0d got %0d", $signed(exp_a.roll), $signed(got.roll));
          if (exp_a.pitch != got.pitch)
            $error("pitch_err expected %0d got %0d", $signed(exp_a.pitch),
                   $signed(got.pitch));
          if (exp_a.yaw != got.yaw)
            $error("yaw_err expected %0d got %0d", $signed(exp_a.yaw), $signed(got.yaw));
          if (exp_a.vrs != got.vrs)
            $error("vrs_detected expected %0d got %0d", exp_a.vrs, got.vrs);
          if (exp_a != got) err_cnt_o <= err_cnt_o + 1;
        end
      end
    end
  end

endmodule

FILE: sim/attitude_error_vrs_detect_tb.sv
// stimulus and verdict for the attitude error / vortex ring detector
// depends on attitude_error_vrs_detect and attitude_error_vrs_detect_chk

module attitude_error_vrs_detect_tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [14:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [175:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [47:0]  m_axis_tdata_o;
  int           err_cnt, pending;
  bit           calm = 1'b0;
  logic [14:0]  hv_list[5] = '{15'd1, 15'd32767, 15'd800, 15'd12000, 15'd0};

  always #5 clk_i = ~clk_i;

  attitude_error_vrs_detect u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  attitude_error_vrs_detect_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_fire_i(s_axis_tvalid_i && s_axis_tready_o), .in_data_i(s_axis_tdata_i),
    .out_fire_i(m_axis_tvalid_o && m_axis_tready_i), .out_data_i(m_axis_tdata_o),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver stalls about 16 in 100 except during the calm stretch
  always @(posedge clk_i) m_axis_tready_i <= calm || ($urandom_range(99) >= 16);

  function automatic logic [15:0] rnd_comp(int mode);
    case (mode)
      0: return 16'($urandom_range(32768) - 16384);
      1: return 16'($urandom_range(600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [175:0] d);
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic pack_send(logic [15:0] q[8], logic [15:0] vx, logic [15:0] vy,
                           logic [15:0] vz);
    send_word({vz, vy, vx, q[7], q[6], q[5], q[4], q[3], q[2], q[1], q[0]});
  endtask

  task automatic drain;
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_hover(logic [14:0] hv);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_words(int n, logic [14:0] hv);
    logic [15:0] q[8];
    logic [15:0] vx, vy, vz;
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(9);
      for (int i = 0; i < 8; i++) q[i] = rnd_comp(mode < 6 ? 0 : (mode < 8 ? 1 : 2));
      if ($urandom_range(9) < 6) begin
        // aim at the vortex ring boundaries
        vz = 16'(-int'(hv) * 28 / 100 - 10 + int'($urandom_range(20))
                 - int'($urandom_range(3000)));
        vx = 16'(int'($urandom_range(int'(hv))) - int'(hv) / 2);
        vy = 16'(int'($urandom_range(int'(hv))) - int'(hv) / 2);
      end else begin
        vx = 16'($urandom); vy = 16'($urandom); vz = 16'($urandom);
      end
      pack_send(q, vx, vy, vz);
    end
  endtask

  initial begin
    logic [15:0] q[8];
    logic [14:0] hv;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: identity, zero quaternions, extremes, gimbal, half turn
    q = '{16'd16384, 0, 0, 0, 16'd16384, 0, 0, 0};
    pack_send(q, 0, 0, 0);
    q = '{0, 0, 0, 0, 0, 0, 0, 0};
    pack_send(q, 16'h8000, 16'h7fff, 16'h8000);
    q = '{0, 0, 0, 0, 16'd11585, 16'd11585, 0, 0};
    pack_send(q, 0, 0, 16'h8000);
    q = '{16'd11585, 0, 16'd11585, 0, 16'd16384, 0, 0, 0};
    pack_send(q, 0, 0, -16'sd3000);
    q = '{16'd11585, 0, -16'sd11585, 0, 16'd16384, 0, 0, 0};
    pack_send(q, 16'd100, 16'd100, -16'sd2000);
    q = '{0, 16'd16384, 0, 0, 16'd16384, 0, 0, 0};
    pack_send(q, 0, 0, 0);
    q = '{0, 0, 0, 16'd16384, 16'd16384, 0, 0, 0};
    pack_send(q, 0, 0, -16'sd1401);
    q = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384,
          16'd16384, 16'd16384, 16'd16384, 16'd16384};
    pack_send(q, 16'h7fff, 16'h7fff, 16'h7fff);
    q = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
    pack_send(q, 16'hffff, 16'h0, 16'hffff);
    q = '{16'd16000, 16'd2000, 16'd1500, 16'd1000, 16'd16384, 0, 0, 0};
    pack_send(q, 0, 0, -16'sd1401);
    pack_send(q, 0, 0, -16'sd1400);
    pack_send(q, 16'd2474, 16'd0, -16'sd5000);
    pack_send(q, 16'd2475, 16'd0, -16'sd5000);
    q = '{16'd1, 0, 0, 0, 0, 0, 0, 16'd1};
    pack_send(q, 0, 0, 0);
    random_words(300, 15'd5000);
    // pause until every result is back
    drain();
    foreach (hv_list[j]) begin
      set_hover(hv_list[j]);
      calm = (j == 2);
      random_words(180, hv_list[j]);
      calm = 1'b0;
      drain();
    end
    hv = 15'($urandom_range(32767, 1));
    set_hover(hv);
    random_words(100, hv);
    drain();
    if (err_cnt == 0) begin
      $display("attitude_error_vrs_detect_tb: done, clean");
    end else begin
      $display("attitude_error_vrs_detect_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("attitude_error_vrs_detect_tb: done, errors");
    $finish;
  end

endmodule
